FILE: sv/hsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsf_pkg;

  localparam int FRAC_BITS = 31;

  // Saturation level: 1.0, or all ones when 1.0 does not fit in 32 bits
  localparam logic [31:0] CAP = (FRAC_BITS >= 32) ? 32'hFFFF_FFFF
                                                  : 32'(64'd1 << FRAC_BITS);

  // Quotient of u * 2^FRAC_BITS / s with u <= s needs FRAC_BITS + 1 bits
  localparam int QW = FRAC_BITS + 1;
  localparam int CW = $clog2(FRAC_BITS + 1);

  typedef enum logic [2:0] {
    REG_TRANS_00    = 3'd0,
    REG_TRANS_01    = 3'd1,
    REG_TRANS_10    = 3'd2,
    REG_TRANS_11    = 3'd3,
    REG_INIT_PROB_0 = 3'd4,
    REG_INIT_PROB_1 = 3'd5
  } cfg_reg_e;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    sat32 = (v > 64'(CAP)) ? CAP : v[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/hsf_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hsf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] likelihood_0;
  logic [31:0] likelihood_1;
  logic        first_position;

  modport source (output valid, output likelihood_0, output likelihood_1,
                  output first_position, input ready);
  modport sink (input valid, input likelihood_0, input likelihood_1,
                input first_position, output ready);
endinterface

interface hsf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] forward_0;
  logic [31:0] forward_1;
  logic [31:0] scale_factor;
  logic        zero_scale_error;

  modport source (output valid, output forward_0, output forward_1,
                  output scale_factor, output zero_scale_error, input ready);
  modport sink (input valid, input forward_0, input forward_1,
                input scale_factor, input zero_scale_error, output ready);
endinterface

`default_nettype wire

FILE: sv/hsf_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Fixed-point multiplier, one registered stage: res = sat(a * b >> FRAC_BITS)
module hsf_mul
  import hsf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic [31:0]      res_o
);

  logic [63:0] prod;
  logic [31:0] res_q;

  assign prod = 64'(sat32(64'(a_i))) * 64'(sat32(64'(b_i)));

  always_ff @(posedge clk_i) begin
    res_q <= sat32(prod >> FRAC_BITS);
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: sv/hsf_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Computes sat(num * 2^FRAC_BITS / den) for num <= den, den != 0.
module hsf_div
  import hsf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [31:0]      quo_o
);

  logic [32:0]   rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [31:0]   den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [32:0]   rem_sh;
  logic          ge;

  assign rem_sh = rem_q << 1;
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      if (num_i >= den_i) begin
        rem_d = {1'b0, num_i - den_i};
        quo_d = QW'(1);
      end else begin
        rem_d = {1'b0, num_i};
        quo_d = '0;
      end
      cnt_d = CW'(FRAC_BITS);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_d  = {quo_q[QW-2:0], ge};
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = sat32(64'(quo_q));

endmodule

`default_nettype wire

FILE: sv/hmm_scaled_forward_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Scaled forward step of a two-state hidden Markov model.
// in_i carries two emission likelihoods and a first-position flag; out_o
// returns the normalized forward vector, the scaling sum and a zero-sum
// flag, one result per input transfer. Both are valid/ready channels.
// Configuration (transition matrix, initial distribution) is written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write it only while the
// block is idle, as the block itself does not enforce this. Each item passes
// through the shared 32x32 multiplier (transition sums, then the weighted
// likelihoods), then through two divisions by the scaling sum on one shared
// bit-serial divider, and is then loaded into the output register. A first
// position skips the four transition products; a zero sum skips the
// divisions.
// The next item is accepted once the current one has reached the output
// register, even while that result waits to be taken.
// A stalled receiver holds the result; if a second result is ready before
// the first is taken, it waits inside and no further input is accepted.
// Reset clears the configuration, output valid and the stored forward vector.
module hmm_scaled_forward_step
  import hsf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  hsf_in_if.sink           in_i,
  hsf_out_if.source        out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P00,
    ST_P10,
    ST_P01,
    ST_P11,
    ST_U0,
    ST_U1,
    ST_SUM,
    ST_DIV0,
    ST_DIV1,
    ST_DONE
  } state_e;

  state_e      state_q;
  logic [31:0] trans_00_q, trans_01_q, trans_10_q, trans_11_q;
  logic [31:0] init_0_q, init_1_q;
  logic [31:0] pf0_q, pf1_q;
  logic [31:0] l0_q, l1_q;
  logic        first_q;
  logic [31:0] acc_q, p0_q, p1_q, u0_q, u1_q, s_q, f0_q, f1_q;
  logic        err_q;
  logic        out_valid_q;
  logic [31:0] out_f0_q, out_f1_q, out_s_q;
  logic        out_err_q;

  logic [31:0] mul_a, mul_b, mul_res;
  logic [31:0] sum_res;
  logic        div_start, div_done;
  logic [31:0] div_num, div_den, div_quo;
  logic        out_free;

  hsf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  hsf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Shared adder: transition sums and the scaling sum
  assign sum_res  = sat32(64'({1'b0, acc_q} + {1'b0, mul_res}));
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    mul_a = pf0_q;
    mul_b = trans_00_q;
    unique case (state_q)
      ST_P10: begin
        mul_a = pf1_q;
        mul_b = trans_10_q;
      end
      ST_P01: begin
        mul_a = pf0_q;
        mul_b = trans_01_q;
      end
      ST_P11: begin
        mul_a = pf1_q;
        mul_b = trans_11_q;
      end
      ST_U0: begin
        mul_a = l0_q;
        mul_b = first_q ? init_0_q : p0_q;
      end
      ST_U1: begin
        mul_a = l1_q;
        mul_b = first_q ? init_1_q : p1_q;
      end
      default: begin
        mul_a = pf0_q;
        mul_b = trans_00_q;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = u0_q;
    div_den   = sum_res;
    unique case (state_q)
      ST_SUM: begin
        div_start = (sum_res != '0);
        div_num   = u0_q;
        div_den   = sum_res;
      end
      ST_DIV0: begin
        div_start = div_done;
        div_num   = u1_q;
        div_den   = s_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_00_q <= '0;
      trans_01_q <= '0;
      trans_10_q <= '0;
      trans_11_q <= '0;
      init_0_q   <= '0;
      init_1_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TRANS_00:    trans_00_q <= cfg_wdata_i;
        REG_TRANS_01:    trans_01_q <= cfg_wdata_i;
        REG_TRANS_10:    trans_10_q <= cfg_wdata_i;
        REG_TRANS_11:    trans_11_q <= cfg_wdata_i;
        REG_INIT_PROB_0: init_0_q   <= cfg_wdata_i;
        REG_INIT_PROB_1: init_1_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer with its registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pf0_q       <= '0;
      pf1_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // In ST_DONE the valid flag is set below when the output register is free
      if (out_valid_q && out_o.ready && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            state_q <= in_i.first_position ? ST_U0 : ST_P00;
          end
        end
        ST_P00:  state_q <= ST_P10;
        ST_P10:  state_q <= ST_P01;
        ST_P01:  state_q <= ST_P11;
        ST_P11:  state_q <= ST_U0;
        ST_U0:   state_q <= ST_U1;
        ST_U1:   state_q <= ST_SUM;
        ST_SUM: begin
          state_q <= (sum_res == '0) ? ST_DONE : ST_DIV0;
        end
        ST_DIV0: begin
          if (div_done) begin
            state_q <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            pf0_q   <= f0_q;
            pf1_q   <= div_quo;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_i.valid) begin
      l0_q    <= sat32(64'(in_i.likelihood_0));
      l1_q    <= sat32(64'(in_i.likelihood_1));
      first_q <= in_i.first_position;
    end
    case (state_q)
      ST_P10: acc_q <= mul_res;
      ST_P01: p0_q  <= sum_res;
      ST_P11: acc_q <= mul_res;
      ST_U0:  p1_q  <= sum_res;
      ST_U1: begin
        u0_q  <= mul_res;
        acc_q <= mul_res;
      end
      ST_SUM: begin
        u1_q  <= mul_res;
        s_q   <= sum_res;
        err_q <= (sum_res == '0);
        f0_q  <= '0;
        f1_q  <= '0;
      end
      ST_DIV0: begin
        if (div_done) begin
          f0_q <= div_quo;
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          f1_q <= div_quo;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_f0_q  <= f0_q;
          out_f1_q  <= f1_q;
          out_s_q   <= err_q ? '0 : s_q;
          out_err_q <= err_q;
        end
      end
      default: ;
    endcase
  end

  assign in_i.ready             = (state_q == ST_IDLE);
  assign out_o.valid            = out_valid_q;
  assign out_o.forward_0        = out_f0_q;
  assign out_o.forward_1        = out_f1_q;
  assign out_o.scale_factor     = out_s_q;
  assign out_o.zero_scale_error = out_err_q;

endmodule

`default_nettype wire

FILE: tb/hmm_scaled_forward_step_tb.sv
`timescale 1ns / 1ps

module hmm_scaled_forward_step_tb;
  import hsf_pkg::*;

  localparam int NUM_CFG = int'(REG_INIT_PROB_1) + 1;
  // Indexes past the register list; writes there must change nothing
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [31:0] lik_0;
    logic [31:0] lik_1;
    logic        first;
  } lik_item_t;

  typedef struct packed {
    logic [31:0] fwd_0;
    logic [31:0] fwd_1;
    logic [31:0] scale;
    logic        zero_err;
  } fwd_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  hsf_in_if  in_if ();
  hsf_out_if out_if ();

  hmm_scaled_forward_step i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lik_item_t   likelihood_q [$];
  fwd_result_t forward_expect_q [$];
  logic [31:0] cfg_shadow [NUM_CFG] = '{default: '0};
  logic [31:0] prev_fwd [2] = '{default: '0};

  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  logic recv_blocked = 1'b0;
  int send_gap;
  int recv_stall;
  int mismatch_cnt = 0;
  int items_sent = 0;
  int firsts_sent = 0;
  int results_seen = 0;
  int zero_sums_seen = 0;
  int cfg_sets = 0;
  lik_item_t   next_item;
  fwd_result_t want, got;

  // Saturate at 1.0 in the block's fixed-point format
  function automatic logic [31:0] q_sat(input logic [127:0] v);
    q_sat = (v > 128'(CAP)) ? CAP : v[31:0];
  endfunction

  function automatic logic [31:0] q_mul(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] prod;
    prod = 128'(q_sat(128'(a))) * 128'(q_sat(128'(b)));
    q_mul = q_sat(prod >> FRAC_BITS);
  endfunction

  // Truncating fixed-point quotient; den is never zero here
  function automatic logic [31:0] q_div(input logic [31:0] num, input logic [31:0] den);
    q_div = q_sat((128'(num) << FRAC_BITS) / 128'(den));
  endfunction

  function automatic fwd_result_t forward_predict(input logic [31:0] l0_raw,
                                                  input logic [31:0] l1_raw,
                                                  input logic first);
    logic [31:0] l0, l1, p0, p1, u0, u1, s;
    fwd_result_t r;
    l0 = q_sat(128'(l0_raw));
    l1 = q_sat(128'(l1_raw));
    if (first) begin
      u0 = q_mul(l0, cfg_shadow[REG_INIT_PROB_0]);
      u1 = q_mul(l1, cfg_shadow[REG_INIT_PROB_1]);
    end else begin
      p0 = q_sat(128'(q_mul(prev_fwd[0], cfg_shadow[REG_TRANS_00]))
                 + 128'(q_mul(prev_fwd[1], cfg_shadow[REG_TRANS_10])));
      p1 = q_sat(128'(q_mul(prev_fwd[0], cfg_shadow[REG_TRANS_01]))
                 + 128'(q_mul(prev_fwd[1], cfg_shadow[REG_TRANS_11])));
      u0 = q_mul(l0, p0);
      u1 = q_mul(l1, p1);
    end
    s = q_sat(128'(u0) + 128'(u1));
    if (s == '0) begin
      // keep the stored vector
      r = '{fwd_0: '0, fwd_1: '0, scale: '0, zero_err: 1'b1};
    end else begin
      prev_fwd[0] = q_div(u0, s);
      prev_fwd[1] = q_div(u1, s);
      r = '{fwd_0: prev_fwd[0], fwd_1: prev_fwd[1], scale: s, zero_err: 1'b0};
    end
    return r;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(60, 150);
  endfunction

  function automatic logic [31:0] rand_lik();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 12) return CAP;
    if (r < 20) return $urandom();
    if (r < 28) return $urandom_range(0, 255);
    return $urandom_range(0, int'(CAP));
  endfunction

  function automatic logic [31:0] rand_prob();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return CAP;
    if (r < 28) return $urandom();
    return $urandom_range(0, int'(CAP));
  endfunction

  // Sender: offer queued items, account for each transfer in the predictor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        forward_expect_q.push_back(forward_predict(in_if.likelihood_0, in_if.likelihood_1,
                                                   in_if.first_position));
        items_sent++;
        if (in_if.first_position) firsts_sent++;
      end
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (likelihood_q.size() != 0) begin
        next_item = likelihood_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.likelihood_0 <= next_item.lik_0;
        in_if.likelihood_1 <= next_item.lik_1;
        in_if.first_position <= next_item.first;
        send_gap <= idle_on ? rand_gap() : 0;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: check each transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{fwd_0: out_if.forward_0, fwd_1: out_if.forward_1,
                scale: out_if.scale_factor, zero_err: out_if.zero_scale_error};
        if (forward_expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result with no item pending: fwd %h %h scale %h err %b", $realtime,
                     got.fwd_0, got.fwd_1, got.scale, got.zero_err);
        end else begin
          want = forward_expect_q.pop_front();
          results_seen++;
          if (want.zero_err) zero_sums_seen++;
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: result %0d: fwd %h %h scale %h err %b, expected %h %h %h %b",
                       $realtime, results_seen, got.fwd_0, got.fwd_1, got.scale,
                       got.zero_err, want.fwd_0, want.fwd_1, want.scale, want.zero_err);
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 30) begin
        recv_stall <= rand_gap();
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !recv_blocked;
      end
    end
  end

  // Long receiver hold-off so the block fills up and stalls its input
  initial begin
    wait (hold_request);
    repeat (20) @(posedge clk_i);
    recv_blocked <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
    recv_blocked <= 1'b0;
  end

  initial begin
    #25ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic push_item(input logic [31:0] l0, input logic [31:0] l1, input logic first);
    likelihood_q.push_back('{lik_0: l0, lik_1: l1, first: first});
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx < NUM_CFG) cfg_shadow[idx] = val;
  endtask

  task automatic load_config(input logic [31:0] t00, input logic [31:0] t01,
                             input logic [31:0] t10, input logic [31:0] t11,
                             input logic [31:0] i0, input logic [31:0] i1);
    cfg_write(REG_TRANS_00, t00);
    cfg_write(REG_TRANS_01, t01);
    cfg_write(REG_TRANS_10, t10);
    cfg_write(REG_TRANS_11, t11);
    cfg_write(REG_INIT_PROB_0, i0);
    cfg_write(REG_INIT_PROB_1, i1);
    // dropped write past the register list
    cfg_write(cfg_sets[0] ? REG_SPARE_7 : REG_SPARE_6, $urandom());
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_sets++;
  endtask

  // Wait until every queued item is sent and every predicted result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (likelihood_q.size() != 0 || in_if.valid || forward_expect_q.size() != 0);
  endtask

  task automatic push_sequences(input int n_items);
    int n, len;
    n = 0;
    while (n < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(1, 24);
        push_item(rand_lik(), rand_lik(), 1'b1);
        repeat (len) push_item(rand_lik(), rand_lik(), 1'b0);
        n += len + 1;
      end else begin
        push_item($urandom(), $urandom(), 1'($urandom_range(0, 1)));
        n++;
      end
    end
  endtask

  initial begin
    int ph;
    in_if.valid = 1'b0;
    in_if.likelihood_0 = '0;
    in_if.likelihood_1 = '0;
    in_if.first_position = 1'b0;
    out_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset state: later position on a zero stored vector, first with zero priors
    push_item(CAP, CAP, 1'b0);
    push_item(CAP, CAP, 1'b1);
    wait_drained();

    load_config(32'h6000_0000, 32'h2000_0000, 32'h3333_3333, 32'h4CCC_CCCD,
                32'h4CCC_CCCD, 32'h3333_3333);
    push_item(CAP, CAP, 1'b1);
    push_item(CAP, CAP, 1'b0);
    push_item('0, '0, 1'b0);
    push_item(CAP, '0, 1'b0);
    push_item('0, CAP, 1'b0);
    push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_item(32'h0000_0001, 32'h0000_0001, 1'b0);
    push_item(32'h0000_8000, 32'h7FFF_FFFF, 1'b0);
    push_item(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    push_item(32'hFFFF_FFFE, 32'h0000_0001, 1'b0);
    wait_drained();

    // Registers at and above one: every transition sum saturates
    load_config(CAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, CAP, 32'hFFFF_FFFF, CAP);
    push_item(CAP, CAP, 1'b1);
    push_item(CAP, CAP, 1'b0);
    push_item(32'h4000_0000, 32'h4000_0000, 1'b0);
    wait_drained();

    // Zero transitions: later positions hit the zero sum and keep the state
    load_config('0, '0, '0, '0, CAP, CAP);
    push_item(CAP, 32'h1234_5678, 1'b1);
    push_item(CAP, CAP, 1'b0);
    push_item('0, '0, 1'b1);
    push_item(32'h0000_0002, 32'hFFFF_FFFF, 1'b0);
    wait_drained();

    for (ph = 0; ph < 5; ph++) begin
      if (ph == 4)
        load_config(CAP, CAP, CAP, CAP, CAP, CAP);
      else
        load_config(rand_prob(), rand_prob(), rand_prob(), rand_prob(),
                    rand_prob(), rand_prob());
      idle_on = (ph != 1);
      if (ph == 2) hold_request = 1'b1;
      push_sequences(264);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d positions (%0d sequence starts) over %0d register settings;",
             items_sent, firsts_sent, cfg_sets);
    $display("checked %0d results, %0d of them zero-sum, %0d mismatches, %0d left over.",
             results_seen, zero_sums_seen, mismatch_cnt, forward_expect_q.size());
    if (mismatch_cnt == 0 && forward_expect_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
sv/hsf_pkg.sv
sv/hsf_if.sv
sv/hsf_mul.sv
sv/hsf_div.sv
sv/hmm_scaled_forward_step.sv
tb/hmm_scaled_forward_step_tb.sv
